### rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Widths, masks and byte patterns shared by the UTF-8 stream decoder files.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned REM_W   = 2;

    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    localparam logic [REM_W-1:0] REM_NONE = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               char_valid;
        logic               raw_pass;
        logic [COUNT_W-1:0] char_count;
        logic               text_end;
    } t_char;

endpackage

### rtl/u8d_if.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Valid/ready channels for incoming text bytes and for decoded characters.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::BYTE_W-1:0]   text_byte;
    logic                         end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8d_char_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::CP_W-1:0]     code_point;
    logic                         char_valid;
    logic                         raw_pass;
    logic [u8d_pkg::COUNT_W-1:0]  char_count;
    logic                         text_end;

    modport source (output valid, output code_point, output char_valid, output raw_pass,
                    output char_count, output text_end, input ready);
    modport sink   (input valid, input code_point, input char_valid, input raw_pass,
                    input char_count, input text_end, output ready);
endinterface

### rtl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial UTF-8 decoder that emits code points with a running count.
//
//   Channel   Direction  Payload
//   i_byte    in         text_byte[7:0], end_of_text
//   o_char    out        code_point[20:0], char_valid, raw_pass,
//                        char_count[31:0], text_end
//
// One byte is accepted per cycle while the output is not stalled; its result
// passes through an input register and then an output register.
// Bytes that complete no character move no transaction on the output side,
// unless they end the text.
// Reset is synchronous and clears the pipeline valids and the decoder state.
// A stalled output holds its result while one more byte waits in the input
// register; input ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8d_byte_if.sink     i_byte,
    u8d_char_if.source   o_char
);

    logic                           r_in_valid;
    logic [u8d_pkg::BYTE_W-1:0]     r_in_byte;
    logic                           r_in_last;

    logic [u8d_pkg::REM_W-1:0]      r_remaining, n_remaining;
    logic [u8d_pkg::CP_W-1:0]       r_gathered, n_gathered;
    logic                           r_good, n_good;
    logic [u8d_pkg::COUNT_W-1:0]    r_count, n_count;

    logic                           r_out_valid;
    u8d_pkg::t_char                 r_out, n_out;

    logic                           w_advance;
    logic                           w_have_char;
    logic                           w_raw;
    logic [u8d_pkg::CP_W-1:0]       w_cp;
    logic [u8d_pkg::CP_W-1:0]       w_shifted;
    logic                           w_cont_ok;
    logic                           w_emit;

    assign w_advance    = r_in_valid && (!r_out_valid || o_char.ready);
    assign i_byte.ready = !r_in_valid || w_advance;

    assign w_shifted = {r_gathered[u8d_pkg::CP_W-7:0], r_in_byte[5:0]};
    assign w_cont_ok = (r_in_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_TAG;

    always_comb begin
        n_remaining = r_remaining;
        n_gathered  = r_gathered;
        n_good      = r_good;
        w_have_char = 1'b0;
        w_raw       = 1'b0;
        w_cp        = '0;
        if (r_remaining != u8d_pkg::REM_NONE) begin
            n_good      = r_good && w_cont_ok;
            n_gathered  = w_shifted;
            n_remaining = r_remaining - u8d_pkg::REM_ONE;
            if (r_remaining == u8d_pkg::REM_ONE && n_good) begin
                w_have_char = 1'b1;
                w_cp        = w_shifted;
            end
        end else if (r_in_byte <= u8d_pkg::ASCII_MAX) begin
            w_have_char = 1'b1;
            w_cp        = u8d_pkg::CP_W'(r_in_byte);
        end else if ((r_in_byte & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_TAG) begin
            n_remaining = u8d_pkg::REM_ONE;
            n_gathered  = u8d_pkg::CP_W'(r_in_byte[4:0]);
            n_good      = 1'b1;
        end else if ((r_in_byte & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_TAG) begin
            n_remaining = u8d_pkg::REM_TWO;
            n_gathered  = u8d_pkg::CP_W'(r_in_byte[3:0]);
            n_good      = 1'b1;
        end else if ((r_in_byte & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_TAG) begin
            n_remaining = u8d_pkg::REM_THREE;
            n_gathered  = u8d_pkg::CP_W'(r_in_byte[2:0]);
            n_good      = 1'b1;
        end else begin
            w_have_char = 1'b1;
            w_raw       = 1'b1;
            w_cp        = u8d_pkg::CP_W'(r_in_byte);
        end

        n_count = w_have_char ? r_count + u8d_pkg::COUNT_W'(1) : r_count;

        n_out.code_point = w_cp;
        n_out.char_valid = w_have_char;
        n_out.raw_pass   = w_raw;
        n_out.char_count = n_count;
        n_out.text_end   = r_in_last;

        if (r_in_last) begin
            n_remaining = u8d_pkg::REM_NONE;
            n_gathered  = '0;
            n_good      = 1'b1;
            n_count     = '0;
        end
    end

    assign w_emit = w_advance && (w_have_char || r_in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_remaining <= u8d_pkg::REM_NONE;
            r_gathered  <= '0;
            r_good      <= 1'b1;
            r_count     <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_advance) begin
                r_remaining <= n_remaining;
                r_gathered  <= n_gathered;
                r_good      <= n_good;
                r_count     <= n_count;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_char.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.text_byte;
            r_in_last <= i_byte.end_of_text;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_char.valid      = r_out_valid;
    assign o_char.code_point = r_out.code_point;
    assign o_char.char_valid = r_out.char_valid;
    assign o_char.raw_pass   = r_out.raw_pass;
    assign o_char.char_count = r_out.char_count;
    assign o_char.text_end   = r_out.text_end;

endmodule

### rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level assertions for the UTF-8 stream decoder, bound to utf8_stream_decoder_core.
// ----------------------------------------------------------------------------
module u8d_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [u8d_pkg::CP_W-1:0]       i_code_point,
    input logic                           i_char_valid,
    input logic                           i_raw_pass,
    input logic [u8d_pkg::COUNT_W-1:0]    i_char_count,
    input logic                           i_text_end
);

    logic r_after_end;
    logic w_out_take;

    assign w_out_take = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b0;
        end else if (w_out_take) begin
            r_after_end <= i_text_end;
        end
    end

    a_raw_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_raw_pass) |-> (i_char_valid && i_code_point[20:8] == '0
            && i_code_point[7]))
        else $error("raw result is not a character byte of 0x80 or above");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_char_valid) |-> (i_text_end && i_code_point == '0
            && !i_raw_pass))
        else $error("result without a character is not an empty end-of-text result");

    a_count_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && r_after_end) |->
            (i_char_count == u8d_pkg::COUNT_W'(i_char_valid)))
        else $error("count did not restart after end of text");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_code_point)
            && $stable(i_char_count)))
        else $error("stalled result transaction changed");

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_char.valid),
    .i_out_ready  (o_char.ready),
    .i_code_point (o_char.code_point),
    .i_char_valid (o_char.char_valid),
    .i_raw_pass   (o_char.raw_pass),
    .i_char_count (o_char.char_count),
    .i_text_end   (o_char.text_end)
);
